### rtl/two_point_calibration_sequencer_top_macros.svh
// ---------------------------------------------------------------------------
// Calibration sequencer assertion macros
// Concurrent check wrappers; they compile to nothing when SYNTH is set.
// ---------------------------------------------------------------------------
`ifndef TWO_POINT_CALIBRATION_SEQUENCER_TOP_MACROS_SVH
`define TWO_POINT_CALIBRATION_SEQUENCER_TOP_MACROS_SVH

`ifndef SYNTH
// Check a property on an explicit clock and active-low reset.
`define TPC_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Check a property on the block clock and reset.
`define TPC_ASSERT(lbl, prop, msg) `TPC_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define TPC_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define TPC_ASSERT(lbl, prop, msg)
`endif

`endif

### rtl/tpc_pkg.sv
// ---------------------------------------------------------------------------
// Calibration sequencer package
// Shared codes, register layout and the result word layout.
// ---------------------------------------------------------------------------
package tpc_pkg;

  // Host commands
  typedef enum logic [3:0] {
    CMD_KEY1     = 4'd0,
    CMD_KEY2     = 4'd1,
    CMD_SELECT   = 4'd2,
    CMD_LIVE     = 4'd3,
    CMD_CAP_ZERO = 4'd4,
    CMD_CAP_SPAN = 4'd5,
    CMD_APPLY    = 4'd6,
    CMD_ABORT    = 4'd7,
    CMD_READ     = 4'd8
  } cmd_e;

  typedef enum logic [2:0] {
    ST_LOCKED   = 3'd0,
    ST_READY    = 3'd1,
    ST_ZERO     = 3'd2,
    ST_SPAN     = 3'd3,
    ST_COMPLETE = 3'd4,
    ST_ERROR    = 3'd5
  } cal_state_e;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_LOCKED   = 3'd1,
    ERR_BAD_ARG  = 3'd2,
    ERR_NO_LIVE  = 3'd3,
    ERR_SEQUENCE = 3'd4,
    ERR_SMALL    = 3'd5
  } err_e;

  // Register index taken from the word address
  typedef enum logic [0:0] {
    REG_UNLOCK   = 1'b0,
    REG_MIN_SPAN = 1'b1
  } reg_e;

  localparam int ADDR_W   = 3;
  localparam int CODE_W   = 16;
  localparam int SPAN_W   = 20;
  localparam int DATA_W   = 32;
  localparam int REV_W    = 16;
  // Table index before trimming: channel field (4 bits) by profile field (3 bits)
  localparam int IDXF_W   = 7;

  localparam logic [CODE_W-1:0]        UNLOCK_RESET   = 16'd0;
  localparam logic [SPAN_W-1:0]        MIN_SPAN_RESET = 20'd1000;
  localparam logic signed [DATA_W-1:0] SPAN_RESET     = 32'sd30000;

  typedef struct packed {
    logic [CODE_W-1:0] unlock_code;
    logic [SPAN_W-1:0] min_span;
  } cfg_t;

  typedef struct packed {
    logic                     ok;
    cal_state_e               cal_state;
    err_e                     err;
    logic [2:0]               sel_ch;
    logic [1:0]               sel_pr;
    logic signed [DATA_W-1:0] live;
    logic                     present;
    logic signed [DATA_W-1:0] pzero;
    logic signed [DATA_W-1:0] pspan;
    logic [REV_W-1:0]         rev;
    logic                     rd_ok;
  } res_t;

endpackage

### rtl/two_point_calibration_sequencer_top.sv
// ---------------------------------------------------------------------------
// Two-point calibration sequencer
// Guarded zero/span capture with a per-channel, per-profile result table.
//
//   channel   direction   handshake                 payload
//   in        host->blk   in_valid_i / in_stall_o   command, key, channel, profile, sample
//   out       blk->host   out_valid_o / out_stall_i status, selection, points, table read
//   cfg       host->blk   APB psel/penable/pready   unlock code @0x0, min span @0x4
//
// One word is taken per cycle while the result channel is not stalled; a word
// passes from the input register to the result register when it executes.
// The rate is set by the single execute step between the input and result registers.
// Reset is asynchronous active low; the table needs no clearing pass, since
// per-entry valid bits give the reset values at once.
// A stalled result holds while one more word waits in the input register.
// ---------------------------------------------------------------------------
`include "two_point_calibration_sequencer_top_macros.svh"

module two_point_calibration_sequencer_top #(
  parameter int CHANNELS = 8,
  parameter int PROFILES = 4
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [tpc_pkg::ADDR_W-1:0]         paddr,
  input  logic [tpc_pkg::DATA_W-1:0]         pwdata,
  output logic [tpc_pkg::DATA_W-1:0]         prdata,
  output logic                               pready,
  // command channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [3:0]                         command_i,
  input  logic [15:0]                        key_value_i,
  input  logic [3:0]                         channel_i,
  input  logic [2:0]                         profile_i,
  input  logic signed [31:0]                 sample_uv_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               ok_o,
  output logic [2:0]                         cal_state_o,
  output logic [2:0]                         error_code_o,
  output logic [2:0]                         selected_channel_o,
  output logic [1:0]                         selected_profile_o,
  output logic signed [31:0]                 live_value_o,
  output logic                               live_present_o,
  output logic signed [31:0]                 pending_zero_o,
  output logic signed [31:0]                 pending_span_o,
  output logic [15:0]                        revision_count_o,
  output logic signed [31:0]                 table_zero_o,
  output logic signed [31:0]                 table_span_o
);

  localparam int DEPTH = CHANNELS * PROFILES;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  tpc_pkg::cfg_t cfg;

  // Input register
  logic               in_valid_q;
  logic [3:0]         cmd_q;
  logic [15:0]        key_q;
  logic [3:0]         ch_q;
  logic [2:0]         pr_q;
  logic signed [31:0] smp_q;
  logic               in_take, advance;

  // Result register
  logic               out_valid_q;
  tpc_pkg::res_t      res_d, res_q;

  // Table port
  logic               tbl_we;
  logic [IDX_W-1:0]   tbl_waddr, tbl_raddr;
  logic signed [31:0] tbl_wzero, tbl_wspan, tbl_rzero, tbl_rspan;

  tpc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Execute the held word once the result register is free or draining
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q <= command_i;
      key_q <= key_value_i;
      ch_q  <= channel_i;
      pr_q  <= profile_i;
      smp_q <= sample_uv_i;
    end
  end

  tpc_core #(
    .CHANNELS (CHANNELS),
    .PROFILES (PROFILES),
    .DEPTH    (DEPTH),
    .IDX_W    (IDX_W)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .exec_i      (advance),
    .cmd_i       (cmd_q),
    .key_i       (key_q),
    .ch_i        (ch_q),
    .pr_i        (pr_q),
    .smp_i       (smp_q),
    .cfg_i       (cfg),
    .res_o       (res_d),
    .tbl_we_o    (tbl_we),
    .tbl_waddr_o (tbl_waddr),
    .tbl_wzero_o (tbl_wzero),
    .tbl_wspan_o (tbl_wspan),
    .tbl_raddr_o (tbl_raddr)
  );

  // Read data is registered inside the table, alongside the result register
  tpc_table #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (tbl_we && advance),
    .wr_addr_i (tbl_waddr),
    .wr_zero_i (tbl_wzero),
    .wr_span_i (tbl_wspan),
    .rd_en_i   (advance),
    .rd_addr_i (tbl_raddr),
    .rd_zero_o (tbl_rzero),
    .rd_span_o (tbl_rspan)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign ok_o               = res_q.ok;
  assign cal_state_o        = res_q.cal_state;
  assign error_code_o       = res_q.err;
  assign selected_channel_o = res_q.sel_ch;
  assign selected_profile_o = res_q.sel_pr;
  assign live_value_o       = res_q.live;
  assign live_present_o     = res_q.present;
  assign pending_zero_o     = res_q.pzero;
  assign pending_span_o     = res_q.pspan;
  assign revision_count_o   = res_q.rev;
  // Drop table data for every word but a valid read
  assign table_zero_o       = res_q.rd_ok ? tbl_rzero : '0;
  assign table_span_o       = res_q.rd_ok ? tbl_rspan : '0;

  // A new result only ever comes from a held word
  `TPC_ASSERT(a_result_from_word, $rose(out_valid_q) |-> $past(in_valid_q), "result without word")
  // Revision never falls back to zero once counting
  `TPC_ASSERT(a_rev_nonzero, (out_valid_q && advance && (res_q.rev != '0)) |=> (res_q.rev != '0), "revision returned to zero")
  // Error state always carries a cause
  `TPC_ASSERT(a_err_cause, (out_valid_q && (res_q.cal_state == tpc_pkg::ST_ERROR)) |-> (res_q.err != tpc_pkg::ERR_NONE), "error state without code")
  // A failed word never shows table data
  `TPC_ASSERT(a_fail_no_table, (out_valid_q && !res_q.ok) |-> ((table_zero_o == '0) && (table_span_o == '0)), "table data on failure")

endmodule

### rtl/tpc_cfg_regs.sv
// ---------------------------------------------------------------------------
// Calibration sequencer configuration registers
// APB-style register file holding the unlock code and the minimum span.
// ---------------------------------------------------------------------------
module tpc_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tpc_pkg::ADDR_W-1:0]  paddr,
  input  logic [tpc_pkg::DATA_W-1:0]  pwdata,
  output logic [tpc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output tpc_pkg::cfg_t               cfg_o
);

  logic [tpc_pkg::CODE_W-1:0] unlock_q;
  logic [tpc_pkg::SPAN_W-1:0] min_span_q;
  logic                       wr_en;
  tpc_pkg::reg_e              reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = tpc_pkg::reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unlock_q   <= tpc_pkg::UNLOCK_RESET;
      min_span_q <= tpc_pkg::MIN_SPAN_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        tpc_pkg::REG_UNLOCK:   unlock_q   <= pwdata[tpc_pkg::CODE_W-1:0];
        tpc_pkg::REG_MIN_SPAN: min_span_q <= pwdata[tpc_pkg::SPAN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      tpc_pkg::REG_UNLOCK:   prdata = tpc_pkg::DATA_W'(unlock_q);
      tpc_pkg::REG_MIN_SPAN: prdata = tpc_pkg::DATA_W'(min_span_q);
      default:               prdata = '0;
    endcase
  end

  assign cfg_o.unlock_code = unlock_q;
  assign cfg_o.min_span    = min_span_q;

endmodule

### rtl/tpc_table.sv
// ---------------------------------------------------------------------------
// Calibration sequencer zero/span table
// One write port, one registered read port; valid bits give reset values.
// ---------------------------------------------------------------------------
module tpc_table #(
  parameter int DEPTH = 32,
  parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               wr_en_i,
  input  logic [IDX_W-1:0]                   wr_addr_i,
  input  logic signed [tpc_pkg::DATA_W-1:0]  wr_zero_i,
  input  logic signed [tpc_pkg::DATA_W-1:0]  wr_span_i,
  input  logic                               rd_en_i,
  input  logic [IDX_W-1:0]                   rd_addr_i,
  output logic signed [tpc_pkg::DATA_W-1:0]  rd_zero_o,
  output logic signed [tpc_pkg::DATA_W-1:0]  rd_span_o
);

  logic signed [tpc_pkg::DATA_W-1:0] zero_mem [DEPTH];
  logic signed [tpc_pkg::DATA_W-1:0] span_mem [DEPTH];
  logic [DEPTH-1:0]                  vld_q;
  logic                              rd_vld_q;
  logic signed [tpc_pkg::DATA_W-1:0] rd_zero_q;
  logic signed [tpc_pkg::DATA_W-1:0] rd_span_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      zero_mem[wr_addr_i] <= wr_zero_i;
      span_mem[wr_addr_i] <= wr_span_i;
    end
    if (rd_en_i) begin
      rd_zero_q <= zero_mem[rd_addr_i];
      rd_span_q <= span_mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  // Unwritten entries read as their reset values
  assign rd_zero_o = rd_vld_q ? rd_zero_q : '0;
  assign rd_span_o = rd_vld_q ? rd_span_q : tpc_pkg::SPAN_RESET;

endmodule

### rtl/tpc_core.sv
// ---------------------------------------------------------------------------
// Calibration sequencer core
// Sequence state, keys, selection, live samples and pending points.
// ---------------------------------------------------------------------------
module tpc_core #(
  parameter int CHANNELS = 8,
  parameter int PROFILES = 4,
  parameter int DEPTH    = CHANNELS * PROFILES,
  parameter int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               exec_i,
  input  logic [3:0]                         cmd_i,
  input  logic [15:0]                        key_i,
  input  logic [3:0]                         ch_i,
  input  logic [2:0]                         pr_i,
  input  logic signed [tpc_pkg::DATA_W-1:0]  smp_i,
  input  tpc_pkg::cfg_t                      cfg_i,
  output tpc_pkg::res_t                      res_o,
  output logic                               tbl_we_o,
  output logic [IDX_W-1:0]                   tbl_waddr_o,
  output logic signed [tpc_pkg::DATA_W-1:0]  tbl_wzero_o,
  output logic signed [tpc_pkg::DATA_W-1:0]  tbl_wspan_o,
  output logic [IDX_W-1:0]                   tbl_raddr_o
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PR_W = (PROFILES > 1) ? $clog2(PROFILES) : 1;
  localparam int IF_W = tpc_pkg::IDXF_W;
  localparam int DW   = tpc_pkg::DATA_W;

  tpc_pkg::cmd_e       cmd;
  tpc_pkg::cal_state_e state_q, state_d;
  tpc_pkg::err_e       err_q, err_d;

  logic [15:0]              key1_q, key2_q, key1_n, key2_n;
  logic [CH_W-1:0]          sel_ch_q, sel_ch_d, ch_idx;
  logic [PR_W-1:0]          sel_pr_q, sel_pr_d, pr_idx;
  logic signed [DW-1:0]     zero_q, zero_d, span_q, span_d;
  logic [tpc_pkg::REV_W-1:0] rev_q, rev_d, rev_inc;
  logic signed [DW-1:0]     live_q [CHANNELS];
  logic [CHANNELS-1:0]      flag_q;

  logic                     unlocked, unlocked_n, ch_ok, pr_ok;
  logic signed [DW-1:0]     live_cur, span_opnd;
  logic                     flag_cur, live_we, too_small, ok;
  logic signed [DW:0]       diff, min_s;
  logic [IF_W-1:0]          waddr_full, raddr_full;
  logic [3:0]               sel_ch_ext;
  logic [2:0]               sel_pr_ext;

  assign cmd = tpc_pkg::cmd_e'(cmd_i);

  assign ch_ok  = {1'b0, ch_i} < 5'(CHANNELS);
  assign pr_ok  = {1'b0, pr_i} < 4'(PROFILES);
  assign ch_idx = ch_i[CH_W-1:0];
  assign pr_idx = pr_i[PR_W-1:0];

  assign key1_n     = (cmd == tpc_pkg::CMD_KEY1) ? key_i : key1_q;
  assign key2_n     = (cmd == tpc_pkg::CMD_KEY2) ? key_i : key2_q;
  assign unlocked   = (key1_q == cfg_i.unlock_code) && (key2_q == cfg_i.unlock_code);
  assign unlocked_n = (key1_n == cfg_i.unlock_code) && (key2_n == cfg_i.unlock_code);

  assign live_cur = live_q[sel_ch_q];
  assign flag_cur = flag_q[sel_ch_q];

  // Span test at full precision: capture checks the live sample, apply the
  // stored span point
  assign span_opnd = (cmd == tpc_pkg::CMD_APPLY) ? span_q : live_cur;
  assign diff      = {span_opnd[DW-1], span_opnd} - {zero_q[DW-1], zero_q};
  assign min_s     = {{(DW + 1 - tpc_pkg::SPAN_W){1'b0}}, cfg_i.min_span};
  assign too_small = (diff > -min_s) && (diff < min_s);

  assign live_we = (cmd == tpc_pkg::CMD_LIVE) && ch_ok;

  // Next sequence state and error code
  always_comb begin
    state_d = state_q;
    err_d   = err_q;
    unique case (cmd)
      tpc_pkg::CMD_KEY1, tpc_pkg::CMD_KEY2: begin
        state_d = unlocked_n ? tpc_pkg::ST_READY : tpc_pkg::ST_LOCKED;
      end
      tpc_pkg::CMD_SELECT: begin
        if (!unlocked) begin
          state_d = tpc_pkg::ST_ERROR;
          err_d   = tpc_pkg::ERR_LOCKED;
        end else if (!(ch_ok && pr_ok)) begin
          state_d = tpc_pkg::ST_ERROR;
          err_d   = tpc_pkg::ERR_BAD_ARG;
        end else begin
          state_d = tpc_pkg::ST_READY;
          err_d   = tpc_pkg::ERR_NONE;
        end
      end
      tpc_pkg::CMD_CAP_ZERO: begin
        if (!unlocked) begin
          state_d = tpc_pkg::ST_ERROR;
          err_d   = tpc_pkg::ERR_LOCKED;
        end else if (!flag_cur) begin
          state_d = tpc_pkg::ST_ERROR;
          err_d   = tpc_pkg::ERR_NO_LIVE;
        end else begin
          state_d = tpc_pkg::ST_ZERO;
          err_d   = tpc_pkg::ERR_NONE;
        end
      end
      tpc_pkg::CMD_CAP_SPAN: begin
        if (state_q != tpc_pkg::ST_ZERO) begin
          state_d = tpc_pkg::ST_ERROR;
          err_d   = tpc_pkg::ERR_SEQUENCE;
        end else if (!flag_cur) begin
          state_d = tpc_pkg::ST_ERROR;
          err_d   = tpc_pkg::ERR_NO_LIVE;
        end else if (too_small) begin
          state_d = tpc_pkg::ST_ERROR;
          err_d   = tpc_pkg::ERR_SMALL;
        end else begin
          state_d = tpc_pkg::ST_SPAN;
          err_d   = tpc_pkg::ERR_NONE;
        end
      end
      tpc_pkg::CMD_APPLY: begin
        if (state_q != tpc_pkg::ST_SPAN) begin
          state_d = tpc_pkg::ST_ERROR;
          err_d   = tpc_pkg::ERR_SEQUENCE;
        end else if (too_small) begin
          state_d = tpc_pkg::ST_ERROR;
          err_d   = tpc_pkg::ERR_SMALL;
        end else begin
          state_d = tpc_pkg::ST_COMPLETE;
          err_d   = tpc_pkg::ERR_NONE;
        end
      end
      tpc_pkg::CMD_ABORT: begin
        state_d = unlocked ? tpc_pkg::ST_READY : tpc_pkg::ST_LOCKED;
        err_d   = tpc_pkg::ERR_NONE;
      end
      default: ;
    endcase
  end

  assign rev_inc = rev_q + 1'b1;

  // Data updates and command status
  always_comb begin
    ok       = 1'b1;
    sel_ch_d = sel_ch_q;
    sel_pr_d = sel_pr_q;
    zero_d   = zero_q;
    span_d   = span_q;
    rev_d    = rev_q;
    tbl_we_o = 1'b0;
    case (cmd)
      tpc_pkg::CMD_KEY1, tpc_pkg::CMD_KEY2, tpc_pkg::CMD_LIVE: ;
      tpc_pkg::CMD_SELECT: begin
        ok = (err_d == tpc_pkg::ERR_NONE);
        if (ok) begin
          sel_ch_d = ch_idx;
          sel_pr_d = pr_idx;
          zero_d   = '0;
          span_d   = '0;
        end
      end
      tpc_pkg::CMD_CAP_ZERO: begin
        ok = (err_d == tpc_pkg::ERR_NONE);
        if (ok) begin
          zero_d = live_cur;
        end
      end
      tpc_pkg::CMD_CAP_SPAN: begin
        ok = (err_d == tpc_pkg::ERR_NONE);
        if (ok) begin
          span_d = live_cur;
        end
      end
      tpc_pkg::CMD_APPLY: begin
        ok = (err_d == tpc_pkg::ERR_NONE);
        if (ok) begin
          tbl_we_o = 1'b1;
          // skip zero on wrap
          rev_d    = (rev_inc == '0) ? tpc_pkg::REV_W'(1) : rev_inc;
        end
      end
      tpc_pkg::CMD_ABORT: begin
        zero_d = '0;
        span_d = '0;
      end
      tpc_pkg::CMD_READ: begin
        ok = ch_ok && pr_ok;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key1_q   <= '0;
      key2_q   <= '0;
      state_q  <= tpc_pkg::ST_LOCKED;
      err_q    <= tpc_pkg::ERR_NONE;
      sel_ch_q <= '0;
      sel_pr_q <= '0;
      zero_q   <= '0;
      span_q   <= '0;
      rev_q    <= '0;
      flag_q   <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        live_q[i] <= '0;
      end
    end else if (exec_i) begin
      key1_q   <= key1_n;
      key2_q   <= key2_n;
      state_q  <= state_d;
      err_q    <= err_d;
      sel_ch_q <= sel_ch_d;
      sel_pr_q <= sel_pr_d;
      zero_q   <= zero_d;
      span_q   <= span_d;
      rev_q    <= rev_d;
      if (live_we) begin
        live_q[ch_idx] <= smp_i;
        flag_q[ch_idx] <= 1'b1;
      end
    end
  end

  // Table addresses: written at the selection, read at the command's fields
  assign waddr_full  = IF_W'(sel_ch_q) * IF_W'(PROFILES) + IF_W'(sel_pr_q);
  assign raddr_full  = IF_W'(ch_i) * IF_W'(PROFILES) + IF_W'(pr_i);
  assign tbl_waddr_o = waddr_full[IDX_W-1:0];
  assign tbl_raddr_o = raddr_full[IDX_W-1:0];
  assign tbl_wzero_o = zero_q;
  assign tbl_wspan_o = span_q;

  assign sel_ch_ext = 4'(sel_ch_d);
  assign sel_pr_ext = 3'(sel_pr_d);

  // Result word shows the state after the command; forward a live sample
  // landing on the selected channel
  always_comb begin
    res_o.ok        = ok;
    res_o.cal_state = state_d;
    res_o.err       = err_d;
    res_o.sel_ch    = sel_ch_ext[2:0];
    res_o.sel_pr    = sel_pr_ext[1:0];
    res_o.live      = (live_we && (ch_idx == sel_ch_d)) ? smp_i : live_q[sel_ch_d];
    res_o.present   = (live_we && (ch_idx == sel_ch_d)) || flag_q[sel_ch_d];
    res_o.pzero     = zero_d;
    res_o.pspan     = span_d;
    res_o.rev       = rev_d;
    res_o.rd_ok     = (cmd == tpc_pkg::CMD_READ) && ch_ok && pr_ok;
  end

endmodule
